@@ sv/mms_pkg.sv @@
`timescale 1ns / 1ps

package mms_pkg;

  localparam int TICK_W  = 20;
  localparam int LIMIT_W = 20;
  localparam int SAMPLE_W = 20;
  localparam int Q_W     = 21;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 32;
  localparam int G_W     = 8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CMD   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] CMD_OK       = 3'd0;
  localparam logic [2:0] CMD_RESET    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_ACCEL    = 3'd3;
  localparam logic [2:0] CMD_SELFTEST = 3'd4;

  localparam logic [2:0] MODE_DEFAULT  = 3'd0;
  localparam logic [2:0] MODE_ERROR    = 3'd1;
  localparam logic [2:0] MODE_RESET    = 3'd2;
  localparam logic [2:0] MODE_STOPPING = 3'd3;
  localparam logic [2:0] MODE_ACCEL    = 3'd4;
  localparam logic [2:0] MODE_SELFTEST = 3'd5;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_CURRENT = 2'd1;
  localparam logic [1:0] FAULT_VOLTAGE = 2'd2;

  localparam logic [1:0] REG_TICK    = 2'd0;
  localparam logic [1:0] REG_CURRENT = 2'd1;
  localparam logic [1:0] REG_VOLTAGE = 2'd2;

  localparam logic [TICK_W-1:0]  TICK_RESET  = 20'd6554;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd784466;

  localparam logic signed [Q_W-1:0] Q_ONE          = 21'sd65536;
  localparam logic signed [Q_W-1:0] V_MAX          = 21'sd655360;
  localparam logic signed [Q_W-1:0] BRAKE_FAST_LIM = 21'sd98304;
  localparam logic signed [Q_W-1:0] BRAKE_SLOW_LIM = 21'sd6554;
  localparam logic signed [Q_W-1:0] BRAKE_FAST     = 21'sd65536;
  localparam logic signed [Q_W-1:0] BRAKE_SLOW     = 21'sd3277;

  typedef struct packed {
    logic [TIME_W-1:0]       time_nxt;
    logic [POS_W-1:0]        pos_nxt;
    logic signed [Q_W-1:0]   vel_nxt;
    logic [G_W-1:0]          g;
  } kin_t;

endpackage

@@ sv/mms_kin.sv @@
`timescale 1ns / 1ps

module mms_kin (
  input  logic [mms_pkg::TIME_W-1:0]     time_i,
  input  logic [mms_pkg::POS_W-1:0]      pos_i,
  input  logic signed [mms_pkg::Q_W-1:0] vel_i,
  input  logic signed [mms_pkg::Q_W-1:0] acc_i,
  input  logic [mms_pkg::TICK_W-1:0]     dt_i,
  output mms_pkg::kin_t                  kin_o
);

  logic signed [41:0] vel_x;
  logic signed [41:0] acc_x;
  logic signed [41:0] dt_x;
  logic signed [41:0] vprod;
  logic signed [41:0] aprod;
  logic signed [26:0] vsum;
  logic signed [25:0] a10;
  logic signed [25:0] gsum;

  assign vel_x = 42'(vel_i);
  assign acc_x = 42'(acc_i);
  assign dt_x  = $signed({22'd0, dt_i});
  assign vprod = vel_x * dt_x;
  assign aprod = acc_x * dt_x;

  assign vsum = 27'(vel_i) + 27'($signed(aprod[41:16]));

  assign a10  = (26'(acc_i) <<< 3) + (26'(acc_i) <<< 1);
  assign gsum = a10 + (a10[25] ? 26'sd65535 : 26'sd0);

  always_comb begin
    kin_o.time_nxt = time_i + 32'(dt_i);
    kin_o.pos_nxt  = pos_i + {{6{vprod[41]}}, vprod[41:16]};
    if (vsum > 27'(mms_pkg::V_MAX)) begin
      kin_o.vel_nxt = mms_pkg::V_MAX;
    end else if (vsum < -27'(mms_pkg::V_MAX)) begin
      kin_o.vel_nxt = -mms_pkg::V_MAX;
    end else begin
      kin_o.vel_nxt = vsum[20:0];
    end
    kin_o.g = gsum[23:16];
  end

endmodule

@@ sv/mms_core.sv @@
`timescale 1ns / 1ps

module mms_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  logic [1:0]                      op,
  input  logic [2:0]                      cmd,
  input  logic signed [mms_pkg::Q_W-1:0]  req,
  input  logic [mms_pkg::SAMPLE_W-1:0]    cur,
  input  logic [mms_pkg::SAMPLE_W-1:0]    volt,
  input  logic [mms_pkg::TICK_W-1:0]      dt,
  input  logic [mms_pkg::LIMIT_W-1:0]     cur_lim,
  input  logic [mms_pkg::LIMIT_W-1:0]     volt_lim,
  output logic                            out_free,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_mode,
  output logic [mms_pkg::TIME_W-1:0]      out_elapsed_time,
  output logic signed [mms_pkg::POS_W-1:0] out_position,
  output logic signed [mms_pkg::Q_W-1:0]  out_velocity,
  output logic signed [mms_pkg::Q_W-1:0]  out_acceleration,
  output logic                            out_lamp,
  output logic [1:0]                      out_fault_code,
  output logic signed [mms_pkg::G_W-1:0]  out_longitudinal_g,
  output logic                            out_selftest_passed
);

  logic [2:0]                     mode_r, mode_nxt;
  logic [mms_pkg::TIME_W-1:0]     time_r, time_nxt;
  logic [mms_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic signed [mms_pkg::Q_W-1:0] vel_r, vel_nxt;
  logic signed [mms_pkg::Q_W-1:0] acc_r, acc_nxt;
  logic                           running_r, running_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [2:0]                     out_mode_r;
  logic [mms_pkg::TIME_W-1:0]     out_time_r;
  logic [mms_pkg::POS_W-1:0]      out_pos_r;
  logic signed [mms_pkg::Q_W-1:0] out_vel_r;
  logic signed [mms_pkg::Q_W-1:0] out_acc_r;
  logic                           out_lamp_r;
  logic [1:0]                     out_fault_r;
  logic [mms_pkg::G_W-1:0]        out_g_r;
  logic                           out_passed_r;

  mms_pkg::kin_t                  kin;
  logic                           produce;
  logic                           lamp;
  logic [1:0]                     fault;
  logic                           passed;
  logic                           brake_done;
  logic signed [mms_pkg::Q_W-1:0] brake_acc;

  mms_kin u_kin (
    .time_i (time_r),
    .pos_i  (pos_r),
    .vel_i  (vel_r),
    .acc_i  (acc_r),
    .dt_i   (dt),
    .kin_o  (kin)
  );

  always_comb begin
    brake_done = 1'b0;
    brake_acc  = acc_r;
    if (kin.vel_nxt > mms_pkg::BRAKE_FAST_LIM) begin
      brake_acc = -mms_pkg::BRAKE_FAST;
    end else if (kin.vel_nxt > mms_pkg::BRAKE_SLOW_LIM) begin
      brake_acc = -mms_pkg::BRAKE_SLOW;
    end else if (kin.vel_nxt < -mms_pkg::BRAKE_FAST_LIM) begin
      brake_acc = mms_pkg::BRAKE_FAST;
    end else if (kin.vel_nxt < -mms_pkg::BRAKE_SLOW_LIM) begin
      brake_acc = mms_pkg::BRAKE_SLOW;
    end else begin
      brake_done = 1'b1;
    end
  end

  always_comb begin
    if (volt > volt_lim) begin
      fault = mms_pkg::FAULT_VOLTAGE;
    end else if (cur > cur_lim) begin
      fault = mms_pkg::FAULT_CURRENT;
    end else begin
      fault = mms_pkg::FAULT_NONE;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    time_nxt    = time_r;
    pos_nxt     = pos_r;
    vel_nxt     = vel_r;
    acc_nxt     = acc_r;
    running_nxt = running_r;
    produce     = 1'b0;
    lamp        = 1'b0;
    passed      = 1'b0;
    if (fire) begin
      unique case (op)
        mms_pkg::OP_START: begin
          mode_nxt    = mms_pkg::MODE_DEFAULT;
          time_nxt    = '0;
          pos_nxt     = '0;
          vel_nxt     = '0;
          acc_nxt     = '0;
          running_nxt = 1'b1;
        end
        mms_pkg::OP_CMD: begin
          unique case (cmd)
            mms_pkg::CMD_OK:    mode_nxt = mms_pkg::MODE_DEFAULT;
            mms_pkg::CMD_RESET: mode_nxt = mms_pkg::MODE_RESET;
            mms_pkg::CMD_STOP:  mode_nxt = mms_pkg::MODE_STOPPING;
            mms_pkg::CMD_ACCEL: begin
              mode_nxt = mms_pkg::MODE_DEFAULT;
              if (req > mms_pkg::V_MAX) begin
                acc_nxt = mms_pkg::V_MAX;
              end else if (req < -mms_pkg::V_MAX) begin
                acc_nxt = -mms_pkg::V_MAX;
              end else begin
                acc_nxt = req;
              end
            end
            mms_pkg::CMD_SELFTEST: begin
              acc_nxt  = mms_pkg::Q_ONE;
              mode_nxt = mms_pkg::MODE_SELFTEST;
            end
            default: ;
          endcase
        end
        mms_pkg::OP_TICK: begin
          if (running_r) begin
            produce  = 1'b1;
            time_nxt = kin.time_nxt;
            pos_nxt  = kin.pos_nxt;
            vel_nxt  = kin.vel_nxt;
            lamp     = (kin.vel_nxt == mms_pkg::V_MAX);
            unique case (mode_r)
              mms_pkg::MODE_DEFAULT: begin
                if (fault != mms_pkg::FAULT_NONE) begin
                  mode_nxt    = mms_pkg::MODE_ERROR;
                  lamp        = 1'b1;
                  running_nxt = 1'b0;
                end
              end
              mms_pkg::MODE_ERROR: lamp = 1'b1;
              mms_pkg::MODE_RESET: begin
                mode_nxt = mms_pkg::MODE_DEFAULT;
                pos_nxt  = '0;
                vel_nxt  = '0;
                acc_nxt  = '0;
                lamp     = 1'b0;
              end
              mms_pkg::MODE_STOPPING: begin
                acc_nxt = brake_acc;
                if (brake_done) begin
                  mode_nxt = mms_pkg::MODE_DEFAULT;
                  acc_nxt  = '0;
                end
              end
              mms_pkg::MODE_SELFTEST: begin
                lamp    = 1'b1;
                acc_nxt = brake_acc;
                if (brake_done) begin
                  passed   = 1'b1;
                  mode_nxt = mms_pkg::MODE_RESET;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && produce) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mms_pkg::MODE_DEFAULT;
      time_r      <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      time_r      <= time_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
      acc_r       <= acc_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      out_mode_r   <= mode_nxt;
      out_time_r   <= time_nxt;
      out_pos_r    <= pos_nxt;
      out_vel_r    <= vel_nxt;
      out_acc_r    <= acc_nxt;
      out_lamp_r   <= lamp;
      out_fault_r  <= (mode_r == mms_pkg::MODE_DEFAULT) ? fault : mms_pkg::FAULT_NONE;
      out_g_r      <= kin.g;
      out_passed_r <= passed;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_mode_r;
  assign out_elapsed_time    = out_time_r;
  assign out_position        = $signed(out_pos_r);
  assign out_velocity        = out_vel_r;
  assign out_acceleration    = out_acc_r;
  assign out_lamp            = out_lamp_r;
  assign out_fault_code      = out_fault_r;
  assign out_longitudinal_g  = $signed(out_g_r);
  assign out_selftest_passed = out_passed_r;

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vel_r <= mms_pkg::V_MAX) && (vel_r >= -mms_pkg::V_MAX))
    else $error("velocity state out of range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && op == mms_pkg::OP_START) |=>
      (running_r && mode_r == mms_pkg::MODE_DEFAULT && vel_r == '0 && time_r == '0))
    else $error("start did not clear motion state");

  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r != mms_pkg::FAULT_NONE) |->
      (out_mode_r == mms_pkg::MODE_ERROR && out_lamp_r))
    else $error("fault reported without error mode");

  a_fault_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && produce && mode_r == mms_pkg::MODE_DEFAULT && fault != mms_pkg::FAULT_NONE)
      |=> !running_r)
    else $error("fault did not halt ticking");

  a_passed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_passed_r) |-> (out_mode_r == mms_pkg::MODE_RESET))
    else $error("self test pass without reset mode");

endmodule

@@ sv/motion_mode_supervisor.sv @@
`timescale 1ns / 1ps

// One-axis motion simulator with mode supervisor. In the compute stage, an
// item sits in the input register, and the integrator and mode rules update
// the motion state and load the result register when the item fires, so an
// item is accepted every cycle unless a result is held by out_stall while
// the input register is full. A result passes the input register and then
// the result register, and comes only for ticks while running. Configuration
// writes always complete (cfg_ready is tied high); write only while idle.
module motion_mode_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [19:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [2:0]                       in_command,
  input  logic signed [mms_pkg::Q_W-1:0]   in_accel_request,
  input  logic [mms_pkg::SAMPLE_W-1:0]     in_current_sample,
  input  logic [mms_pkg::SAMPLE_W-1:0]     in_voltage_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_mode,
  output logic [mms_pkg::TIME_W-1:0]       out_elapsed_time,
  output logic signed [mms_pkg::POS_W-1:0] out_position,
  output logic signed [mms_pkg::Q_W-1:0]   out_velocity,
  output logic signed [mms_pkg::Q_W-1:0]   out_acceleration,
  output logic                             out_lamp,
  output logic [1:0]                       out_fault_code,
  output logic signed [mms_pkg::G_W-1:0]   out_longitudinal_g,
  output logic                             out_selftest_passed
);

  logic [mms_pkg::TICK_W-1:0]     tick_r;
  logic [mms_pkg::LIMIT_W-1:0]    cur_lim_r;
  logic [mms_pkg::LIMIT_W-1:0]    volt_lim_r;

  logic                           item_v_r, item_v_nxt;
  logic [1:0]                     op_r;
  logic [2:0]                     cmd_r;
  logic signed [mms_pkg::Q_W-1:0] req_r;
  logic [mms_pkg::SAMPLE_W-1:0]   cur_r;
  logic [mms_pkg::SAMPLE_W-1:0]   volt_r;

  logic                           out_free;
  logic                           fire;
  logic                           accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= mms_pkg::TICK_RESET;
      cur_lim_r  <= mms_pkg::LIMIT_RESET;
      volt_lim_r <= mms_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mms_pkg::REG_TICK:    tick_r     <= cfg_data;
        mms_pkg::REG_CURRENT: cur_lim_r  <= cfg_data;
        mms_pkg::REG_VOLTAGE: volt_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire     = item_v_r && out_free;
  assign in_stall = item_v_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_v_nxt = item_v_r;
    if (accept) begin
      item_v_nxt = 1'b1;
    end else if (fire) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      cmd_r  <= in_command;
      req_r  <= in_accel_request;
      cur_r  <= in_current_sample;
      volt_r <= in_voltage_sample;
    end
  end

  mms_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fire                (fire),
    .op                  (op_r),
    .cmd                 (cmd_r),
    .req                 (req_r),
    .cur                 (cur_r),
    .volt                (volt_r),
    .dt                  (tick_r),
    .cur_lim             (cur_lim_r),
    .volt_lim            (volt_lim_r),
    .out_free            (out_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_mode            (out_mode),
    .out_elapsed_time    (out_elapsed_time),
    .out_position        (out_position),
    .out_velocity        (out_velocity),
    .out_acceleration    (out_acceleration),
    .out_lamp            (out_lamp),
    .out_fault_code      (out_fault_code),
    .out_longitudinal_g  (out_longitudinal_g),
    .out_selftest_passed (out_selftest_passed)
  );

endmodule
